// ===== hdl/generational_handle_allocator_defines.svh =====
// Assertion macros for the generational handle allocator.
// Used by the top level only; no other dependencies.
`ifndef GENERATIONAL_HANDLE_ALLOCATOR_DEFINES_SVH
`define GENERATIONAL_HANDLE_ALLOCATOR_DEFINES_SVH
`define GHA_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`define GHA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

// ===== hdl/gha_pkg.sv =====
// Shared types and constants for the generational handle allocator.
// No dependencies.
`default_nettype none
package gha_pkg;
	localparam int MAX_SLOTS = 1024;
	localparam int IDX_W = 10;
	localparam int CNT_W = 11;
	localparam int GEN_W = 16;
	localparam int GRP_W = 16;
	localparam int PLACE_W = 32;
	localparam int FUNC_W = 3;
	localparam logic [GRP_W-1:0] NO_GROUP = '1;

	typedef enum logic [FUNC_W-1:0] {
		F_CREATE = 3'd0,
		F_DESTROY = 3'd1,
		F_QUERY = 3'd2,
		F_UPDATE = 3'd3,
		F_FIND = 3'd4
	} func_t;

	typedef enum logic [2:0] {
		OP_NONE = 3'd0,
		OP_CREATE = 3'd1,
		OP_DESTROY = 3'd2,
		OP_QUERY = 3'd3,
		OP_UPDATE = 3'd4,
		OP_FIND = 3'd5
	} op_t;

	typedef struct packed {
		logic load;      // latch request, start read at slot_index / free stack
		logic read_scan; // read entry at scan pointer
		logic scan_init; // scan pointer to zero
		logic scan_step; // advance scan pointer
		logic exec;      // perform op on read data, emit result
		logic found;     // find: emit match at previous scan entry
		logic miss;      // find: emit not found
		op_t op;
	} cmd_t;

	typedef struct packed {
		logic match;     // scan entry read last cycle matches
		logic scan_last; // scan pointer at last allocated slot
		logic empty;     // nothing allocated
	} stat_t;
endpackage
`default_nettype wire

// ===== hdl/gha_ctrl.sv =====
// Controller state machine of the generational handle allocator.
// Depends on gha_pkg.
`default_nettype none
module gha_ctrl (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic [2:0] func,
	input wire gha_pkg::stat_t stat,
	output gha_pkg::cmd_t cmd,
	output logic busy
);
	import gha_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_EXEC = 4'b0010,
		S_SCAN = 4'b0100,
		S_CHK = 4'b1000
	} state_t;

	state_t state_q, state_d;
	op_t op_q, op_d;

	always_comb begin
		op_d = OP_NONE;
		case (func)
			F_CREATE: op_d = OP_CREATE;
			F_DESTROY: op_d = OP_DESTROY;
			F_QUERY: op_d = OP_QUERY;
			F_UPDATE: op_d = OP_UPDATE;
			F_FIND: op_d = OP_FIND;
			default: op_d = OP_NONE;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.op = op_q;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					cmd.op = op_d;
					if (op_d == OP_FIND) begin
						cmd.scan_init = 1'b1;
						state_d = S_SCAN;
					end else begin
						state_d = S_EXEC;
					end
				end
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
				state_d = S_IDLE;
			end
			S_SCAN: begin
				if (stat.empty) begin
					cmd.miss = 1'b1;
					state_d = S_IDLE;
				end else begin
					cmd.read_scan = 1'b1;
					state_d = S_CHK;
				end
			end
			S_CHK: begin
				if (stat.match) begin
					cmd.found = 1'b1;
					state_d = S_IDLE;
				end else if (stat.scan_last) begin
					cmd.miss = 1'b1;
					state_d = S_IDLE;
				end else begin
					cmd.scan_step = 1'b1;
					cmd.read_scan = 1'b1;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q <= OP_NONE;
		end else begin
			state_q <= state_d;
			if (cmd.load) op_q <= op_d;
		end
	end

	assign busy = (state_q != S_IDLE);
endmodule
`default_nettype wire

// ===== hdl/gha_dp.sv =====
// Datapath of the generational handle allocator: slot memories, free stack,
// counters and result registers. Depends on gha_pkg.
`default_nettype none
module gha_dp (
	input wire logic clk,
	input wire logic arst_n,
	input wire gha_pkg::cmd_t cmd,
	input wire logic [gha_pkg::IDX_W-1:0] slot_index,
	input wire logic [gha_pkg::GEN_W-1:0] slot_generation,
	input wire logic [gha_pkg::GRP_W-1:0] group_id,
	input wire logic [gha_pkg::PLACE_W-1:0] place_word,
	output gha_pkg::stat_t stat,
	output logic done,
	output logic ok,
	output logic [gha_pkg::IDX_W-1:0] out_index,
	output logic [gha_pkg::GEN_W-1:0] out_generation,
	output logic [gha_pkg::GRP_W-1:0] out_group,
	output logic [gha_pkg::PLACE_W-1:0] out_place,
	output logic [gha_pkg::CNT_W-1:0] live_count
);
	import gha_pkg::*;

	logic [GEN_W-1:0] gen_mem [MAX_SLOTS];
	logic [GRP_W-1:0] grp_mem [MAX_SLOTS];
	logic [PLACE_W-1:0] place_mem [MAX_SLOTS];
	logic [IDX_W-1:0] stk_mem [MAX_SLOTS];

	logic [CNT_W-1:0] free_top_q, high_water_q, live_q;
	logic [IDX_W-1:0] idx_q, scan_q;
	logic [GEN_W-1:0] hgen_q, rgen_q;
	logic [GRP_W-1:0] grp_q, rgrp_q;
	logic [PLACE_W-1:0] place_q, rplace_q;
	logic [IDX_W-1:0] rstk_q;
	logic [IDX_W-1:0] raddr;

	logic [CNT_W-1:0] top_m1;
	assign top_m1 = free_top_q - CNT_W'(1);

	always_comb begin
		raddr = slot_index;
		if (cmd.read_scan) raddr = cmd.scan_step ? scan_q + IDX_W'(1) : scan_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.load || cmd.read_scan) begin
			rgen_q <= gen_mem[raddr];
			rgrp_q <= grp_mem[raddr];
			rplace_q <= place_mem[raddr];
		end
		if (cmd.load) rstk_q <= stk_mem[top_m1[IDX_W-1:0]];
	end

	logic live;
	assign live = (hgen_q != '0) && ({1'b0, idx_q} < high_water_q) && (rgen_q == hgen_q);

	logic [GEN_W-1:0] gen_inc;
	always_comb begin
		gen_inc = rgen_q + GEN_W'(1);
		if (gen_inc == '0) gen_inc = GEN_W'(1);
	end

	logic create_pop, create_new, des_ok, upd_ok;
	assign create_pop = cmd.exec && cmd.op == OP_CREATE && free_top_q != '0;
	assign create_new = cmd.exec && cmd.op == OP_CREATE && free_top_q == '0
		&& high_water_q != CNT_W'(MAX_SLOTS);
	assign des_ok = cmd.exec && cmd.op == OP_DESTROY && live;
	assign upd_ok = cmd.exec && cmd.op == OP_UPDATE && live;

	always_ff @(posedge clk) begin
		if (create_new) begin
			gen_mem[high_water_q[IDX_W-1:0]] <= GEN_W'(1);
			grp_mem[high_water_q[IDX_W-1:0]] <= NO_GROUP;
			place_mem[high_water_q[IDX_W-1:0]] <= '0;
		end else if (des_ok || upd_ok) begin
			if (des_ok) gen_mem[idx_q] <= gen_inc;
			grp_mem[idx_q] <= des_ok ? NO_GROUP : grp_q;
			place_mem[idx_q] <= des_ok ? '0 : place_q;
		end
		if (des_ok && free_top_q != CNT_W'(MAX_SLOTS))
			stk_mem[free_top_q[IDX_W-1:0]] <= idx_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			idx_q <= slot_index;
			hgen_q <= slot_generation;
			grp_q <= group_id;
			place_q <= place_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_top_q <= '0;
			high_water_q <= '0;
			live_q <= '0;
			scan_q <= '0;
		end else begin
			if (cmd.scan_init) scan_q <= '0;
			else if (cmd.scan_step) scan_q <= scan_q + IDX_W'(1);
			if (create_pop) begin
				free_top_q <= top_m1;
				live_q <= live_q + CNT_W'(1);
			end else if (create_new) begin
				high_water_q <= high_water_q + CNT_W'(1);
				live_q <= live_q + CNT_W'(1);
			end else if (des_ok) begin
				if (free_top_q != CNT_W'(MAX_SLOTS)) free_top_q <= free_top_q + CNT_W'(1);
				if (live_q != '0) live_q <= live_q - CNT_W'(1);
			end
		end
	end

	assign stat.match = (rgrp_q == grp_q) && (rplace_q == place_q) && (rgen_q != '0);
	assign stat.scan_last = ({1'b0, scan_q} == high_water_q - CNT_W'(1));
	assign stat.empty = (high_water_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= cmd.exec || cmd.found || cmd.miss;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec || cmd.found || cmd.miss) begin
			ok <= 1'b0;
			out_index <= '0;
			out_generation <= '0;
			out_group <= '0;
			out_place <= '0;
			if (cmd.found) begin
				ok <= 1'b1;
				out_index <= scan_q;
				out_generation <= rgen_q;
			end else if (cmd.exec) begin
				case (cmd.op)
					OP_CREATE: begin
						if (create_pop) begin
							ok <= 1'b1;
							out_index <= rstk_q;
							out_generation <= gen_mem[rstk_q];
						end else if (create_new) begin
							ok <= 1'b1;
							out_index <= high_water_q[IDX_W-1:0];
							out_generation <= GEN_W'(1);
						end
					end
					OP_DESTROY, OP_UPDATE: ok <= live;
					OP_QUERY: begin
						if (live) begin
							ok <= 1'b1;
							out_group <= rgrp_q;
							out_place <= rplace_q;
						end
					end
					default: ok <= 1'b0;
				endcase
			end
		end
	end

	assign live_count = live_q;
endmodule
`default_nettype wire

// ===== hdl/generational_handle_allocator.sv =====
// Top level of the generational handle allocator.
// Depends on gha_pkg, gha_ctrl, gha_dp and the assertion macro header.
//
// Usage: drive func and the handle/location fields with start high while busy
// is low; that request is accepted on that edge. One result follows, shown
// for exactly one cycle with done high: ok, out_index, out_generation,
// out_group, out_place, live_count. The receiver cannot stall; it must take
// the result in that cycle.
// Create, destroy, query, update and unknown codes go from accept to done
// through one memory read, then the write-back and result.
// Find walks the allocated slots one per cycle through the single memory
// read port, up to the high-water mark.
// busy is low again in the cycle done is high, so the next request may be
// accepted then.
// Reset: arst_n clears the counters and controller; slot memories are not
// cleared and are only used where written.
`default_nettype none
`include "generational_handle_allocator_defines.svh"
module generational_handle_allocator (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	output logic busy,
	input wire logic [2:0] func,
	input wire logic [gha_pkg::IDX_W-1:0] slot_index,
	input wire logic [gha_pkg::GEN_W-1:0] slot_generation,
	input wire logic [gha_pkg::GRP_W-1:0] group_id,
	input wire logic [gha_pkg::PLACE_W-1:0] place_word,
	output logic done,
	output logic ok,
	output logic [gha_pkg::IDX_W-1:0] out_index,
	output logic [gha_pkg::GEN_W-1:0] out_generation,
	output logic [gha_pkg::GRP_W-1:0] out_group,
	output logic [gha_pkg::PLACE_W-1:0] out_place,
	output logic [gha_pkg::CNT_W-1:0] live_count
);
	import gha_pkg::*;

	cmd_t cmd;
	stat_t stat;

	gha_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .func(func),
		.stat(stat), .cmd(cmd), .busy(busy)
	);

	gha_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd),
		.slot_index(slot_index), .slot_generation(slot_generation),
		.group_id(group_id), .place_word(place_word),
		.stat(stat), .done(done), .ok(ok), .out_index(out_index),
		.out_generation(out_generation), .out_group(out_group),
		.out_place(out_place), .live_count(live_count)
	);

	`GHA_ASSERT_NEXT(a_accept_busy, clk, arst_n, start && !busy, busy,
		"accepted request did not raise busy")
	`GHA_ASSERT_IMPL(a_done_idle, clk, arst_n, done, !busy,
		"result shown while still busy")
	`GHA_ASSERT_IMPL(a_live_bound, clk, arst_n, 1'b1,
		live_count <= CNT_W'(MAX_SLOTS), "live count above slot count")
endmodule
`default_nettype wire

// ===== verif/generational_handle_allocator_tb.sv =====
// Testbench for generational_handle_allocator: directed and random requests
// checked result by result against a behavioral predictor in a scoreboard.
// Depends on gha_pkg and the generational_handle_allocator RTL.
`timescale 1ns / 1ps
`default_nettype none

module generational_handle_allocator_tb;
	import gha_pkg::*;

	localparam logic [FUNC_W-1:0] FUNC_FIRST_UNUSED = 3'd5;
	localparam logic [FUNC_W-1:0] FUNC_LAST_UNUSED = 3'd7;
	localparam int LIMIT_CYCLES = 6000000;
	localparam int N_RANDOM = 800;

	typedef struct {
		logic ok;
		logic [IDX_W-1:0] index;
		logic [GEN_W-1:0] gen;
		logic [GRP_W-1:0] grp;
		logic [PLACE_W-1:0] place;
		logic [CNT_W-1:0] live;
	} alloc_result_t;

	class gha_scoreboard;
		logic [GEN_W-1:0] gen_mem[MAX_SLOTS];
		logic [GRP_W-1:0] grp_mem[MAX_SLOTS];
		logic [PLACE_W-1:0] place_mem[MAX_SLOTS];
		logic [IDX_W-1:0] free_list[MAX_SLOTS];
		int free_top;
		int high_water;
		int live_total;
		alloc_result_t pending_results[$];
		int errors;

		function new();
			free_top = 0;
			high_water = 0;
			live_total = 0;
			errors = 0;
		endfunction

		function bit is_live(logic [IDX_W-1:0] idx, logic [GEN_W-1:0] gen);
			if (gen == '0 || idx >= high_water)
				return 0;
			return gen_mem[idx] == gen;
		endfunction

		function void note_request(logic [FUNC_W-1:0] fn, logic [IDX_W-1:0] idx,
				logic [GEN_W-1:0] gen, logic [GRP_W-1:0] grp, logic [PLACE_W-1:0] pl);
			alloc_result_t r;
			int slot;
			r = '{1'b0, '0, '0, '0, '0, '0};
			case (fn)
				F_CREATE: begin
					slot = -1;
					if (free_top > 0) begin
						free_top--;
						slot = int'(free_list[free_top]);
					end else if (high_water < MAX_SLOTS) begin
						slot = high_water;
						high_water++;
						gen_mem[slot] = GEN_W'(1);
						grp_mem[slot] = NO_GROUP;
						place_mem[slot] = '0;
					end
					if (slot >= 0) begin
						live_total++;
						r.ok = 1'b1;
						r.index = IDX_W'(slot);
						r.gen = gen_mem[slot];
					end
				end
				F_DESTROY: begin
					if (is_live(idx, gen)) begin
						gen_mem[idx] = gen_mem[idx] + 1'b1;
						if (gen_mem[idx] == '0)
							gen_mem[idx] = GEN_W'(1);
						grp_mem[idx] = NO_GROUP;
						place_mem[idx] = '0;
						if (free_top < MAX_SLOTS) begin
							free_list[free_top] = idx;
							free_top++;
						end
						if (live_total > 0)
							live_total--;
						r.ok = 1'b1;
					end
				end
				F_QUERY: begin
					if (is_live(idx, gen)) begin
						r.ok = 1'b1;
						r.grp = grp_mem[idx];
						r.place = place_mem[idx];
					end
				end
				F_UPDATE: begin
					if (is_live(idx, gen)) begin
						grp_mem[idx] = grp;
						place_mem[idx] = pl;
						r.ok = 1'b1;
					end
				end
				F_FIND: begin
					for (int i = 0; i < high_water; i++) begin
						if (grp_mem[i] == grp && place_mem[i] == pl && gen_mem[i] != '0) begin
							r.ok = 1'b1;
							r.index = IDX_W'(i);
							r.gen = gen_mem[i];
							break;
						end
					end
				end
				default: ;
			endcase
			r.live = CNT_W'(live_total);
			pending_results.insert(pending_results.size(), r);
		endfunction

		function void check_result(alloc_result_t act);
			alloc_result_t e;
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result ok=%0b index=%0d", $time, act.ok, act.index);
				errors++;
				return;
			end
			e = pending_results.pop_front();
			if (act.ok !== e.ok) begin
				$display("%0t: ok exp %0b act %0b", $time, e.ok, act.ok);
				errors++;
			end
			if (act.index !== e.index) begin
				$display("%0t: out_index exp %0d act %0d", $time, e.index, act.index);
				errors++;
			end
			if (act.gen !== e.gen) begin
				$display("%0t: out_generation exp %0d act %0d", $time, e.gen, act.gen);
				errors++;
			end
			if (act.grp !== e.grp) begin
				$display("%0t: out_group exp %h act %h", $time, e.grp, act.grp);
				errors++;
			end
			if (act.place !== e.place) begin
				$display("%0t: out_place exp %h act %h", $time, e.place, act.place);
				errors++;
			end
			if (act.live !== e.live) begin
				$display("%0t: live_count exp %0d act %0d", $time, e.live, act.live);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic [FUNC_W-1:0] func = '0;
	logic [IDX_W-1:0] slot_index = '0;
	logic [GEN_W-1:0] slot_generation = '0;
	logic [GRP_W-1:0] group_id = '0;
	logic [PLACE_W-1:0] place_word = '0;
	logic busy, done, ok;
	logic [IDX_W-1:0] out_index;
	logic [GEN_W-1:0] out_generation;
	logic [GRP_W-1:0] out_group;
	logic [PLACE_W-1:0] out_place;
	logic [CNT_W-1:0] live_count;
	int cycle_count = 0;

	gha_scoreboard sb = new();

	generational_handle_allocator i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.func(func),
		.slot_index(slot_index),
		.slot_generation(slot_generation),
		.group_id(group_id),
		.place_word(place_word),
		.done(done),
		.ok(ok),
		.out_index(out_index),
		.out_generation(out_generation),
		.out_group(out_group),
		.out_place(out_place),
		.live_count(live_count)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_result('{ok, out_index, out_generation, out_group, out_place, live_count});
	end

	// start stays high on return; idle_for with n > 0 or drain lowers it
	task automatic issue(logic [FUNC_W-1:0] fn, logic [IDX_W-1:0] idx,
			logic [GEN_W-1:0] gen, logic [GRP_W-1:0] grp, logic [PLACE_W-1:0] pl);
		func <= fn;
		slot_index <= idx;
		slot_generation <= gen;
		group_id <= grp;
		place_word <= pl;
		start <= 1'b1;
		do
			@(posedge clk);
		while (busy);
		sb.note_request(fn, idx, gen, grp, pl);
	endtask

	task automatic idle_for(int n);
		if (n > 0) begin
			start <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic random_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			idle_for(0);
		else if (r < 92)
			idle_for($urandom_range(1, 3));
		else
			idle_for($urandom_range(10, 40));
	endtask

	task automatic drain();
		start <= 1'b0;
		while (sb.pending_results.size() != 0)
			@(posedge clk);
	endtask

	// random handle: mostly a live one, sometimes stale, out of range or invalid
	task automatic pick_handle(output logic [IDX_W-1:0] idx, output logic [GEN_W-1:0] gen);
		int r;
		r = $urandom_range(0, 99);
		idx = IDX_W'($urandom);
		gen = GEN_W'($urandom);
		if (sb.high_water > 0 && r < 75) begin
			idx = IDX_W'($urandom_range(0, sb.high_water - 1));
			gen = sb.gen_mem[idx];
		end else if (sb.high_water > 0 && r < 85) begin
			idx = IDX_W'($urandom_range(0, sb.high_water - 1));
			gen = sb.gen_mem[idx] - 1'b1;
		end else if (r < 90) begin
			gen = '0;
		end
	endtask

	task automatic random_request();
		logic [IDX_W-1:0] idx;
		logic [GEN_W-1:0] gen;
		logic [GRP_W-1:0] grp;
		logic [PLACE_W-1:0] pl;
		int r;
		pick_handle(idx, gen);
		grp = GRP_W'($urandom);
		pl = PLACE_W'($urandom);
		r = $urandom_range(0, 99);
		if (r < 28) begin
			issue(F_CREATE, idx, gen, grp, pl);
		end else if (r < 48) begin
			issue(F_DESTROY, idx, gen, grp, pl);
		end else if (r < 62) begin
			issue(F_QUERY, idx, gen, grp, pl);
		end else if (r < 82) begin
			if ($urandom_range(0, 3) == 0)
				grp = NO_GROUP;
			issue(F_UPDATE, idx, gen, grp, pl);
		end else if (r < 96) begin
			if (sb.high_water > 0 && $urandom_range(0, 2) != 0) begin
				idx = IDX_W'($urandom_range(0, sb.high_water - 1));
				grp = sb.grp_mem[idx];
				pl = sb.place_mem[idx];
			end else if ($urandom_range(0, 1) == 0) begin
				grp = NO_GROUP;
				pl = '0;
			end
			issue(F_FIND, idx, gen, grp, pl);
		end else begin
			issue(FUNC_W'($urandom_range(FUNC_FIRST_UNUSED, FUNC_LAST_UNUSED)),
				idx, gen, grp, pl);
		end
	endtask

	initial begin
		logic [IDX_W-1:0] idx;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed
		issue(F_FIND, '0, '0, NO_GROUP, '0);
		issue(F_QUERY, '0, 16'd1, '0, '0);
		issue(F_CREATE, '0, '0, '0, '0);
		issue(F_CREATE, '1, '1, '1, '1);
		issue(F_QUERY, 10'd1, '0, '0, '0);
		issue(F_QUERY, 10'd5, 16'd1, '0, '0);
		issue(F_UPDATE, 10'd1, 16'd1, '1, '1);
		issue(F_QUERY, 10'd1, 16'd1, '0, '0);
		issue(F_FIND, '0, '0, '1, '1);
		issue(F_FIND, '0, '0, NO_GROUP, '0);
		issue(F_FIND, '0, '0, 16'h1234, 32'hdead_beef);
		for (logic [FUNC_W-1:0] f = FUNC_FIRST_UNUSED; f != '0; f++)
			issue(f, '1, '1, '1, '1);
		issue(F_DESTROY, '0, 16'd2, '0, '0);
		issue(F_DESTROY, '0, 16'd1, '0, '0);
		issue(F_QUERY, '0, 16'd1, '0, '0);
		issue(F_QUERY, '0, 16'd2, '0, '0);
		issue(F_UPDATE, '0, 16'd1, 16'h0, 32'h1);
		issue(F_FIND, '0, '0, NO_GROUP, '0);
		issue(F_CREATE, '0, '0, '0, '0);
		issue(F_DESTROY, 10'd1, 16'd1, '0, '0);
		idle_for(3);

		// slot reuse: cycle slot 1 through a few generations back-to-back
		idx = 10'd1;
		for (int i = 0; i < 8; i++) begin
			issue(F_CREATE, '0, '0, '0, '0);
			issue(F_DESTROY, idx, sb.gen_mem[idx], '0, '0);
		end
		issue(F_QUERY, idx, 16'd1, '0, '0);
		drain();

		for (int i = 0; i < N_RANDOM; i++) begin
			random_request();
			random_gap();
			if (i == N_RANDOM / 2)
				drain();
		end
		drain();

		// fill the store, then hit it full
		while (sb.high_water < MAX_SLOTS || sb.free_top > 0)
			issue(F_CREATE, '0, '0, '0, '0);
		issue(F_CREATE, '1, '1, '1, '1);
		issue(F_CREATE, '0, '0, '0, '0);
		issue(F_FIND, '0, '0, 16'h4321, 32'h0bad_f00d);
		idx = '1;
		issue(F_UPDATE, idx, sb.gen_mem[idx], 16'h4321, 32'h0bad_f00d);
		issue(F_FIND, '0, '0, 16'h4321, 32'h0bad_f00d);
		issue(F_DESTROY, idx, sb.gen_mem[idx], '0, '0);
		issue(F_QUERY, '1, '1, '0, '0);
		for (int i = 0; i < 40; i++) begin
			random_request();
			random_gap();
		end

		drain();
		repeat (MAX_SLOTS + 20) @(posedge clk);
		if (sb.errors == 0 && sb.pending_results.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end
endmodule

`default_nettype wire
